FILE: rtl/tcce_pkg.sv
// Shared types, character codes and helpers for the text console cursor engine.
`default_nettype none

package tcce_pkg;

   // field widths fixed by the item format
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = 16;

   // default geometry
   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 8;

   // tab search covers every multiple of the smallest stop up to the widest line
   localparam int COL_LIMIT = 128;
   localparam int TAB_MULTS = 64;

   // console control characters
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

   // attribute used by the power-on fill and the color register reset
   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

   typedef enum logic [1:0] {
      OP_CONSOLE = 2'd0,
      OP_WRITE   = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // latch the request beat
      logic exec;        // perform the latched operation
      logic fill_step;   // write one cell of the running sweep
      logic fill_reset;  // sweep writes the power-on blank
      logic rsp_load;    // load the response register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   need_fill;
      logic   fill_last;
      logic   rsp_free;
   } dp_status_type;

   // next tab stop strictly beyond col
   function automatic logic [7:0] next_tab_stop(input logic [COL_W-1:0] col,
                                                input int tab_stop);
      logic [7:0] stop;
      stop = 8'(COL_LIMIT);
      for (int k = TAB_MULTS; k >= 1; k--) begin
         if (k * tab_stop > int'(col)) begin
            stop = 8'(k * tab_stop);
         end
      end
      return stop;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tcce_ctrl.sv
// Sequencer for the text console cursor engine: accept, execute, sweep, respond.
`default_nettype none

module tcce_ctrl
   import tcce_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            // power-on blank of the whole store
            cmd.fill_step  = 1'b1;
            cmd.fill_reset = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.need_fill) begin
               state_in = ST_FILL;
            end else if (status.op == OP_READ) begin
               state_in = ST_RESP;
            end else if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               if (status.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/tcce_datapath.sv
// Cell store, cursor, row ring pointer, sweep counter and response register.
`default_nettype none

module tcce_datapath
   import tcce_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   // request fields
   input  wire op_type             req_operation,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic [COL_W-1:0]   req_col,
   input  wire logic [ROW_W-1:0]   req_row,
   input  wire logic [COLOR_W-1:0] req_cell_color,
   // color register write
   input  wire logic               csr_valid,
   input  wire logic [COLOR_W-1:0] csr_data,
   // response register
   input  wire logic               rsp_tready,
   output logic                    rsp_valid,
   output logic [CELL_W-1:0]       rsp_cell_data,
   output logic [COL_W-1:0]        rsp_cursor_col,
   output logic [ROW_W-1:0]        rsp_cursor_row,
   output logic                    rsp_scrolled
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS - 1);
   localparam logic [7:0]        COL_END   = 8'(COLUMNS);
   localparam logic [ROW_W:0]    ROW_END   = (ROW_W+1)'(ROWS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

   // latched request
   op_type             op_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COLOR_W-1:0] color_ff;

   // architectural state
   logic [COLOR_W-1:0] text_color_ff, text_color_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]   row_base_ff, row_base_in;
   logic [ADDR_W-1:0]  sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]  sweep_end_ff, sweep_end_in;
   logic               scrolled_ff, scrolled_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_cell_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic               rsp_scrolled_ff;

   // cell store
   logic [CELL_W-1:0]  cells_mem [CELL_COUNT];
   logic [CELL_W-1:0]  rd_data_ff;

   logic               in_range;
   logic [7:0]         c_step;
   logic [ROW_W:0]     r_step;
   logic               con_write;
   logic               con_blank;
   logic               wrap;
   logic [ROW_W:0]     r_wrap;
   logic               scroll;
   logic [COL_W-1:0]   con_col;
   logic [ROW_W-1:0]   con_row;
   logic [ROW_W-1:0]   row_sel;
   logic [COL_W-1:0]   col_sel;
   logic [ROW_W:0]     phys_sum;
   logic [ROW_W-1:0]   phys_row;
   logic [ADDR_W-1:0]  cell_addr;
   logic [ADDR_W-1:0]  blank_start;
   logic [CELL_W-1:0]  blank_cell;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CELL_W-1:0]  wr_data;
   logic               rd_en;
   logic               rsp_free;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff    <= req_operation;
         char_ff  <= req_char_code;
         col_ff   <= req_col;
         row_ff   <= req_row;
         color_ff <= req_cell_color;
      end
   end

   assign in_range   = ({1'b0, col_ff} < COL_END) && ({1'b0, row_ff} < ROW_END);
   assign blank_cell = {text_color_ff, CHAR_BLANK};

   // console character: cursor motion and cell effect
   always_comb begin
      c_step    = {1'b0, cur_col_ff};
      r_step    = {1'b0, cur_row_ff};
      con_write = 1'b0;
      con_blank = 1'b0;
      unique case (char_ff)
         CHAR_NEWLINE: begin
            c_step = '0;
            r_step = {1'b0, cur_row_ff} + 1'b1;
         end
         CHAR_RETURN: begin
            c_step = '0;
         end
         CHAR_TAB: begin
            c_step = next_tab_stop(cur_col_ff, TAB_STOP);
         end
         CHAR_BACKSPACE: begin
            // erase the previous cell, nothing at the left edge
            if (cur_col_ff != '0) begin
               c_step    = {1'b0, cur_col_ff} - 1'b1;
               con_write = 1'b1;
               con_blank = 1'b1;
            end
         end
         default: begin
            c_step    = {1'b0, cur_col_ff} + 1'b1;
            con_write = 1'b1;
         end
      endcase
   end

   // line wrap and scroll decision
   assign wrap    = (c_step >= COL_END);
   assign r_wrap  = wrap ? r_step + 1'b1 : r_step;
   assign scroll  = (r_wrap >= ROW_END);
   assign con_col = wrap ? '0 : c_step[COL_W-1:0];
   assign con_row = scroll ? ROW_LAST : r_wrap[ROW_W-1:0];

   // logical row to physical row through the ring pointer
   assign row_sel  = (op_ff == OP_CONSOLE) ? cur_row_ff : row_ff;
   assign col_sel  = (op_ff == OP_CONSOLE) ?
                     (con_blank ? cur_col_ff - 1'b1 : cur_col_ff) : col_ff;
   assign phys_sum = {1'b0, row_sel} + {1'b0, row_base_ff};
   assign phys_row = (phys_sum >= ROW_END) ? ROW_W'(phys_sum - ROW_END)
                                           : phys_sum[ROW_W-1:0];
   assign cell_addr   = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
   // old top row becomes the new bottom row on a scroll
   assign blank_start = ADDR_W'(row_base_ff) * ADDR_W'(COLUMNS);

   // store write and read port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cell_addr;
      wr_data = {color_ff, char_ff};
      rd_en   = 1'b0;
      if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = cmd.fill_reset ? {COLOR_RESET, CHAR_BLANK} : blank_cell;
      end else if (cmd.exec) begin
         unique case (op_ff)
            OP_CONSOLE: begin
               wr_en   = con_write;
               wr_data = con_blank ? blank_cell : {text_color_ff, char_ff};
            end
            OP_WRITE: begin
               wr_en = in_range;
            end
            OP_READ: begin
               rd_en = in_range;
            end
            OP_CLEAR: begin
               wr_en = 1'b0;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_mem[cell_addr];
      end
   end

   // cursor, ring pointer and sweep next values
   always_comb begin
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      row_base_in   = row_base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      scrolled_in   = scrolled_ff;
      text_color_in = csr_valid ? csr_data : text_color_ff;
      if (cmd.fill_step) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end
      if (cmd.exec) begin
         scrolled_in = (op_ff == OP_CONSOLE) && scroll;
         if (op_ff == OP_CONSOLE) begin
            cur_col_in = con_col;
            cur_row_in = con_row;
            if (scroll) begin
               row_base_in   = (row_base_ff == ROW_LAST) ? '0 : row_base_ff + 1'b1;
               sweep_addr_in = blank_start;
               sweep_end_in  = blank_start + ROW_SPAN;
            end
         end else if (op_ff == OP_CLEAR) begin
            cur_col_in    = '0;
            cur_row_in    = '0;
            row_base_in   = '0;
            sweep_addr_in = '0;
            sweep_end_in  = LAST_ADDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_RESET;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         row_base_ff   <= '0;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= LAST_ADDR;
         scrolled_ff   <= 1'b0;
      end else begin
         text_color_ff <= text_color_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         row_base_ff   <= row_base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
         scrolled_ff   <= scrolled_in;
      end
   end

   // response register, takes the cursor as it leaves this cycle
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_cell_ff     <= (op_ff == OP_READ && in_range) ? rd_data_ff : '0;
         rsp_col_ff      <= cur_col_in;
         rsp_row_ff      <= cur_row_in;
         rsp_scrolled_ff <= scrolled_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   // status to the sequencer
   assign status.op        = op_ff;
   assign status.need_fill = (op_ff == OP_CLEAR) || (op_ff == OP_CONSOLE && scroll);
   assign status.fill_last = (sweep_addr_ff == sweep_end_ff);
   assign status.rsp_free  = rsp_free;

   // cursor and ring pointer stay on the screen
   a_cursor_col: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cur_col_ff} < COL_END)
      else $error("cursor column beyond line end");

   a_cursor_row: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cur_row_ff} < ROW_END)
      else $error("cursor row beyond screen");

   a_row_base: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_base_ff} < ROW_END)
      else $error("row ring pointer out of range");

   // sweep never runs past its end mark
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (sweep_addr_ff <= sweep_end_ff && sweep_end_ff <= LAST_ADDR))
      else $error("sweep beyond its end");

   // a pending response is never overwritten
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_engine.sv
// Text console cell store with cursor: top level of the engine.
//
// Request channel req_*: one beat carries one operation (console character,
// write cell at position, clear screen, read cell); req_tuser holds the
// operation code. Response channel rsp_*: exactly one beat per request with
// the read data, the cursor after the operation and a scroll flag.
// csr_* writes the attribute byte used for console writes, blanks and clear;
// it is always ready and should be written only while the engine is idle.
// Order: the response is loaded in the execute state for a console
// character or a cell write when the response register is free, and for a
// read in the response state, after the registered store read. A scroll
// first blanks the new bottom row, since rows live in a ring addressed by a
// base pointer; a clear screen first blanks the whole store (one cell per
// cycle through the single write port). The next request can be taken in
// the cycle after the load.
// After reset the store is blanked with req_tready low. A stalled response
// is held in its register; the next request is still accepted and executed,
// and its response waits.
`default_nettype none

module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // char_code[7:0], col[14:8], row[19:15], cell_color[27:20], zero[31:28]
   input  wire logic [31:0] req_tdata,
   // operation[1:0]
   input  wire logic [1:0]  req_tuser,
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cell_data[15:0], cursor_col[22:16], cursor_row[27:23], zero[31:28]
   output logic [31:0]      rsp_tdata,
   // scrolled[0]
   output logic [0:0]       rsp_tuser,
   // attribute register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [CELL_W-1:0]   rsp_cell_data;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic                rsp_scrolled;

   assign csr_ready = 1'b1;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcce_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (op_type'(req_tuser)),
      .req_char_code  (req_tdata[7:0]),
      .req_col        (req_tdata[14:8]),
      .req_row        (req_tdata[19:15]),
      .req_cell_color (req_tdata[27:20]),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled)
   );

   // pack the response beat
   assign rsp_tdata = {4'b0000, rsp_cursor_row, rsp_cursor_col, rsp_cell_data};
   assign rsp_tuser = rsp_scrolled;

endmodule

`default_nettype wire
